// ----- hw/rtl/led_error_code_blinker_defines.svh -----
// assertion helpers for the led error code blinker
`ifndef LED_ERROR_CODE_BLINKER_DEFINES_SVH
`define LED_ERROR_CODE_BLINKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LEB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LEB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ledblk_pkg.sv -----
package ledblk_pkg;

    localparam int DEF_TIMER_WIDTH = 16;

    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic [CFG_WIDTH-1:0]       cfg_word_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    typedef logic [3:0]                 phase_t;
    typedef logic [3:0]                 digit_t;
    typedef logic [2:0]                 levels_t;

    // register indexes
    localparam cfg_index_t REG_SPACE     = 3'd0;
    localparam cfg_index_t REG_PULSE_ON  = 3'd1;
    localparam cfg_index_t REG_PULSE_OFF = 3'd2;
    localparam cfg_index_t REG_END       = 3'd3;

    localparam cfg_word_t SPACE_RESET     = 16'd200;
    localparam cfg_word_t PULSE_ON_RESET  = 16'd300;
    localparam cfg_word_t PULSE_OFF_RESET = 16'd300;
    localparam cfg_word_t END_RESET       = 16'd1000;

    localparam logic [7:0] CODE_MAX = 8'd99;
    // tens = (code * 103) >> 10, exact for codes up to 99
    localparam logic [13:0] DIV10_RECIP = 14'd103;
    localparam int          DIV10_SHIFT = 10;

    // phase codes
    localparam phase_t PH_MARK0    = 4'd0;
    localparam phase_t PH_MARK1    = 4'd1;
    localparam phase_t PH_MARK2    = 4'd2;
    localparam phase_t PH_MARKGAP  = 4'd3;
    localparam phase_t PH_TENS_ON  = 4'd4;
    localparam phase_t PH_TENS_OFF = 4'd5;
    localparam phase_t PH_SEP_A    = 4'd6;
    localparam phase_t PH_SEP_B    = 4'd7;
    localparam phase_t PH_SEP_ON   = 4'd8;
    localparam phase_t PH_SEP_OFF  = 4'd9;
    localparam phase_t PH_ONES_ON  = 4'd10;
    localparam phase_t PH_ONES_OFF = 4'd11;
    localparam phase_t PH_END      = 4'd12;

    // bit0 = led_one, bit1 = led_two, bit2 = led_three
    function automatic levels_t phase_levels(phase_t ph);
        levels_t lv;
        case (ph)
            PH_MARK0:                           lv = 3'b100;
            PH_MARK1:                           lv = 3'b110;
            PH_MARK2, PH_TENS_ON, PH_ONES_ON:   lv = 3'b111;
            PH_SEP_ON:                          lv = 3'b010;
            default:                            lv = 3'b000;
        endcase
        return lv;
    endfunction

endpackage

// ----- hw/rtl/led_error_code_blinker.sv -----
// channel | valid    | stall     | beat fields
// --------+----------+-----------+----------------------------------------
// in      | in_valid | in_stall  | command, error_code
// out     | out_valid| out_stall | led_one, led_two, led_three, active
// cfg     | cfg_write| (none)    | cfg_index, cfg_data
//
// one beat per cycle while in_stall is low; each input beat yields its result in the
// next cycle from the output register, set by the single phase/timer update path
// in_stall is high only while the output register holds an untaken beat
// reset clears the pattern state and loads the default timing registers
`include "led_error_code_blinker_defines.svh"

module led_error_code_blinker #(
    parameter int TIMER_WIDTH = ledblk_pkg::DEF_TIMER_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  ledblk_pkg::cfg_index_t        cfg_index,
    input  ledblk_pkg::cfg_word_t         cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [7:0]                    error_code,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          led_one,
    output logic                          led_two,
    output logic                          led_three,
    output logic                          active
);

    typedef logic [TIMER_WIDTH-1:0] timer_t;

    ledblk_pkg::cfg_word_t space_reg;
    ledblk_pkg::cfg_word_t pulse_on_reg;
    ledblk_pkg::cfg_word_t pulse_off_reg;
    ledblk_pkg::cfg_word_t end_reg;

    logic                  running_reg, running_next;
    ledblk_pkg::phase_t    phase_reg, phase_next;
    timer_t                timer_reg, timer_next;
    ledblk_pkg::digit_t    count_reg, count_next;
    ledblk_pkg::digit_t    tens_reg, tens_next;
    ledblk_pkg::digit_t    ones_reg, ones_next;

    logic                  out_valid_reg;
    ledblk_pkg::levels_t   levels_reg, levels_next;
    logic                  active_reg;

    logic                  accept;
    logic [6:0]            sat_code;
    logic [13:0]           recip_prod;
    ledblk_pkg::digit_t    code_tens;
    logic [6:0]            tens_ext;
    logic [6:0]            ones_wide;
    ledblk_pkg::cfg_word_t len_sel;
    logic [31:0]           len_ext;
    timer_t                len_raw;
    timer_t                phase_len;
    timer_t                timer_inc;
    logic                  phase_done;
    ledblk_pkg::digit_t    count_inc;

    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;

    assign out_valid = out_valid_reg;
    assign led_one   = levels_reg[0];
    assign led_two   = levels_reg[1];
    assign led_three = levels_reg[2];
    assign active    = active_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_reg     <= ledblk_pkg::SPACE_RESET;
            pulse_on_reg  <= ledblk_pkg::PULSE_ON_RESET;
            pulse_off_reg <= ledblk_pkg::PULSE_OFF_RESET;
            end_reg       <= ledblk_pkg::END_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ledblk_pkg::REG_SPACE:     space_reg     <= cfg_data;
                ledblk_pkg::REG_PULSE_ON:  pulse_on_reg  <= cfg_data;
                ledblk_pkg::REG_PULSE_OFF: pulse_off_reg <= cfg_data;
                ledblk_pkg::REG_END:       end_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturate to 99 and split into digits
    always_comb
    begin
        sat_code   = (error_code > ledblk_pkg::CODE_MAX) ? ledblk_pkg::CODE_MAX[6:0]
                                                         : error_code[6:0];
        recip_prod = 14'(sat_code) * ledblk_pkg::DIV10_RECIP;
        code_tens  = 4'(recip_prod >> ledblk_pkg::DIV10_SHIFT);
        tens_ext   = 7'(code_tens);
        ones_wide  = sat_code - (tens_ext << 3) - (tens_ext << 1);
    end

    // length of the current phase, zero counts as one
    always_comb
    begin
        if (phase_reg <= ledblk_pkg::PH_MARKGAP)
            len_sel = space_reg;
        else if (phase_reg == ledblk_pkg::PH_END)
            len_sel = end_reg;
        else if (phase_reg > ledblk_pkg::PH_END)
            len_sel = ledblk_pkg::cfg_word_t'(1);
        else if (!phase_reg[0])
            len_sel = pulse_on_reg;
        else
            len_sel = pulse_off_reg;
        len_ext   = 32'(len_sel);
        len_raw   = len_ext[TIMER_WIDTH-1:0];
        phase_len = (len_raw == '0) ? TIMER_WIDTH'(1) : len_raw;
    end

    assign timer_inc  = timer_reg + TIMER_WIDTH'(1);
    assign phase_done = (timer_inc == '0) || (timer_inc >= phase_len);
    assign count_inc  = count_reg + 4'd1;

    always_comb
    begin
        running_next = running_reg;
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        count_next   = count_reg;
        tens_next    = tens_reg;
        ones_next    = ones_reg;
        levels_next  = '0;

        if (command)
        begin
            tens_next    = code_tens;
            ones_next    = ones_wide[3:0];
            running_next = 1'b1;
            phase_next   = ledblk_pkg::PH_MARK0;
            timer_next   = '0;
            count_next   = '0;
            levels_next  = ledblk_pkg::phase_levels(ledblk_pkg::PH_MARK0);
        end
        else if (running_reg)
        begin
            levels_next = ledblk_pkg::phase_levels(phase_reg);
            timer_next  = timer_inc;
            if (phase_done)
            begin
                timer_next = '0;
                unique case (phase_reg)
                    ledblk_pkg::PH_MARK0,
                    ledblk_pkg::PH_MARK1,
                    ledblk_pkg::PH_MARK2,
                    ledblk_pkg::PH_SEP_A,
                    ledblk_pkg::PH_SEP_B,
                    ledblk_pkg::PH_SEP_ON:
                        phase_next = phase_reg + 4'd1;
                    ledblk_pkg::PH_MARKGAP:
                    begin
                        count_next = '0;
                        phase_next = (tens_reg == '0) ? ledblk_pkg::PH_SEP_A
                                                      : ledblk_pkg::PH_TENS_ON;
                    end
                    ledblk_pkg::PH_TENS_ON:
                        phase_next = ledblk_pkg::PH_TENS_OFF;
                    ledblk_pkg::PH_TENS_OFF:
                    begin
                        count_next = count_inc;
                        phase_next = (count_inc < tens_reg) ? ledblk_pkg::PH_TENS_ON
                                                            : ledblk_pkg::PH_SEP_A;
                    end
                    ledblk_pkg::PH_SEP_OFF:
                    begin
                        count_next = '0;
                        phase_next = (ones_reg == '0) ? ledblk_pkg::PH_END
                                                      : ledblk_pkg::PH_ONES_ON;
                    end
                    ledblk_pkg::PH_ONES_ON:
                        phase_next = ledblk_pkg::PH_ONES_OFF;
                    ledblk_pkg::PH_ONES_OFF:
                    begin
                        count_next = count_inc;
                        phase_next = (count_inc < ones_reg) ? ledblk_pkg::PH_ONES_ON
                                                            : ledblk_pkg::PH_END;
                    end
                    default:
                        phase_next = ledblk_pkg::PH_MARK0;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            phase_reg   <= ledblk_pkg::PH_MARK0;
            timer_reg   <= '0;
            count_reg   <= '0;
            tens_reg    <= '0;
            ones_reg    <= '0;
        end
        else if (accept)
        begin
            running_reg <= running_next;
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            count_reg   <= count_next;
            tens_reg    <= tens_next;
            ones_reg    <= ones_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            levels_reg <= levels_next;
            active_reg <= running_next;
        end
    end

    `LEB_ASSERT_NEXT(a_beat_lands, accept, out_valid_reg, "accepted beat produced no result")
    `LEB_ASSERT_NEXT(a_start_shows_marker, accept && command,
        active && led_three && !led_two && !led_one, "start beat did not show first marker")
    `LEB_ASSERT_NOW(a_phase_reachable, running_reg, phase_reg <= ledblk_pkg::PH_END,
        "pattern entered an unused phase")
    `LEB_ASSERT_NOW(a_digits_decimal, 1'b1, tens_reg <= 4'd9 && ones_reg <= 4'd9,
        "stored digit out of decimal range")
    `LEB_ASSERT_NOW(a_tens_count_bound,
        phase_reg == ledblk_pkg::PH_TENS_ON || phase_reg == ledblk_pkg::PH_TENS_OFF,
        count_reg < tens_reg, "tens pulse count ran past the digit")

endmodule
